[src/fabs_pkg.sv]
// Package: sizes, types and command codes of the four-axis Bresenham stepper.
package fabs_pkg;

  localparam int AXES          = 4;
  localparam int IN_AXES       = 4;
  localparam int COORD_BITS    = 24;
  localparam int POS_BITS      = 32;
  localparam int DELTA_BITS    = POS_BITS + 1;
  localparam int ERR_BITS      = DELTA_BITS + 1;
  localparam int AXIS_IDX_BITS = (AXES > 1) ? $clog2(AXES) : 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [POS_BITS-1:0]   pos_t;
  typedef logic signed [DELTA_BITS-1:0] delta_t;
  typedef logic        [DELTA_BITS-1:0] mag_t;
  typedef logic signed [ERR_BITS-1:0]   err_t;
  typedef logic [AXIS_IDX_BITS-1:0]     axis_idx_t;
  typedef logic [IN_AXES-1:0]           axis_mask_t;

  typedef enum logic [1:0] {
    MODE_START  = 2'd0,
    MODE_TICK   = 2'd1,
    MODE_SETPOS = 2'd2
  } mode_t;

  typedef struct packed {
    axis_mask_t step_mask;
    axis_mask_t dir_mask;
    logic       busy_res;
    logic       rejected;
    pos_t       pos_x;
    pos_t       pos_y;
    pos_t       pos_u;
    pos_t       pos_v;
  } result_t;

endpackage

[src/fabs_if.sv]
// Interfaces: command channel and result channel of the stepper.
interface fabs_cmd_if;
  import fabs_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  coord_t     target_x;
  coord_t     target_y;
  coord_t     target_u;
  coord_t     target_v;

  modport source (output valid, output mode, output target_x, output target_y,
                  output target_u, output target_v, input ready);
  modport sink   (input valid, input mode, input target_x, input target_y,
                  input target_u, input target_v, output ready);
endinterface

interface fabs_res_if;
  import fabs_pkg::*;
  logic       valid;
  logic       ready;
  axis_mask_t step_mask;
  axis_mask_t dir_mask;
  logic       busy_res;
  logic       rejected;
  pos_t       pos_x;
  pos_t       pos_y;
  pos_t       pos_u;
  pos_t       pos_v;

  modport source (output valid, output step_mask, output dir_mask, output busy_res,
                  output rejected, output pos_x, output pos_y, output pos_u,
                  output pos_v, input ready);
  modport sink   (input valid, input step_mask, input dir_mask, input busy_res,
                  input rejected, input pos_x, input pos_y, input pos_u,
                  input pos_v, output ready);
endinterface

[src/four_axis_bresenham_stepper.sv]
// Top level: four-axis Bresenham step interpolator with a two-entry result buffer.
//
// Channels: cmd carries one command item (start line, timer tick or set
// position plus four signed targets); res returns exactly one result item per
// command: step and direction masks, busy and rejected flags, four positions.
// cfg_wr_en/cfg_wr_data write absolute_mode; the user must write it only
// while the block is idle, which the block itself does not enforce.
// Each command is evaluated in the cycle it is accepted: the axis state
// updates at that edge and the result is registered in the result buffer.
// Throughput: one command per cycle while the buffer has room; the start-line path
// (subtract, magnitude, largest-axis compare chain) and the per-axis error update
// set the clock. The result buffer holds two items; cmd.ready drops only when both
// are full, so a stalled receiver holds results and back-pressures commands after
// two. Reset: positions, deltas and errors clear, no line in progress, relative
// mode, result buffer empty.
module four_axis_bresenham_stepper (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  fabs_cmd_if.sink          cmd,
  fabs_res_if.source        res
);
  import fabs_pkg::*;

  logic      absolute_mode;
  pos_t      pos        [AXES];
  delta_t    delta      [AXES];
  mag_t      mag        [AXES];
  err_t      err        [AXES];
  axis_idx_t major;
  mag_t      major_len;
  mag_t      step_count;
  logic      active;

  pos_t      pos_next   [AXES];
  delta_t    delta_next [AXES];
  mag_t      mag_next   [AXES];
  err_t      err_next   [AXES];
  axis_idx_t major_next;
  mag_t      major_len_next;
  mag_t      step_count_next;
  logic      active_next;
  result_t   res_next;

  coord_t    tgt        [AXES];
  delta_t    d_new      [AXES];
  mag_t      m_new      [AXES];
  err_t      e_sub      [AXES];
  axis_idx_t best_idx;
  mag_t      best_mag;

  result_t   buf_q      [2];
  logic      wr_ptr;
  logic      rd_ptr;
  logic [1:0] count;
  logic      push;
  logic      pop;

  assign cmd.ready = (count != 2'd2);
  assign push      = cmd.valid && cmd.ready;
  assign res.valid = (count != 2'd0);
  assign pop       = res.valid && res.ready;

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      tgt[i] = '0;
    end
    tgt[0] = cmd.target_x;
    if (AXES > 1) tgt[1] = cmd.target_y;
    if (AXES > 2) tgt[2] = cmd.target_u;
    if (AXES > 3) tgt[3] = cmd.target_v;

    for (int i = 0; i < AXES; i++) begin
      d_new[i] = DELTA_BITS'(tgt[i]);
      if (absolute_mode) d_new[i] = d_new[i] - DELTA_BITS'(pos[i]);
      m_new[i] = (d_new[i] < 0) ? mag_t'(-d_new[i]) : mag_t'(d_new[i]);
    end
    best_idx = '0;
    best_mag = m_new[0];
    for (int i = 1; i < AXES; i++) begin
      if (best_mag <= m_new[i]) begin
        best_idx = AXIS_IDX_BITS'(i);
        best_mag = m_new[i];
      end
    end
    for (int i = 0; i < AXES; i++) begin
      e_sub[i] = err[i] - $signed({1'b0, mag[i]});
    end

    pos_next        = pos;
    delta_next      = delta;
    mag_next        = mag;
    err_next        = err;
    major_next      = major;
    major_len_next  = major_len;
    step_count_next = step_count;
    active_next     = active;
    res_next        = '0;

    unique case (cmd.mode)
      MODE_START, MODE_SETPOS: begin
        if (active) begin
          res_next.rejected = 1'b1;
        end else if (cmd.mode == MODE_SETPOS) begin
          for (int i = 0; i < AXES; i++) begin
            pos_next[i] = POS_BITS'(tgt[i]);
          end
        end else begin
          for (int i = 0; i < AXES; i++) begin
            delta_next[i] = d_new[i];
            mag_next[i]   = m_new[i];
            err_next[i]   = $signed({2'b00, best_mag[DELTA_BITS-1:1]});
          end
          major_next      = best_idx;
          major_len_next  = best_mag;
          step_count_next = '0;
          active_next     = 1'b1;
        end
      end
      MODE_TICK: begin
        if (active) begin
          if (step_count < major_len) begin
            for (int i = 0; i < AXES; i++) begin
              if (AXIS_IDX_BITS'(i) != major) begin
                err_next[i] = e_sub[i];
                if (e_sub[i] < 0) begin
                  err_next[i] = e_sub[i] + $signed({1'b0, major_len});
                  if (i < IN_AXES) res_next.step_mask[i] = 1'b1;
                end
              end else if (i < IN_AXES) begin
                res_next.step_mask[i] = 1'b1;
              end
            end
            step_count_next = step_count + 1'b1;
          end else begin
            for (int i = 0; i < AXES; i++) begin
              pos_next[i] = pos[i] + delta[i][POS_BITS-1:0];
            end
            active_next = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase

    for (int i = 0; i < IN_AXES && i < AXES; i++) begin
      res_next.dir_mask[i] = (delta_next[i] >= 0);
    end
    res_next.busy_res = active_next;
    res_next.pos_x    = pos_next[0];
    if (AXES > 1) res_next.pos_y = pos_next[1];
    if (AXES > 2) res_next.pos_u = pos_next[2];
    if (AXES > 3) res_next.pos_v = pos_next[3];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      absolute_mode <= 1'b0;
      for (int i = 0; i < AXES; i++) begin
        pos[i]   <= '0;
        delta[i] <= '0;
        mag[i]   <= '0;
        err[i]   <= '0;
      end
      major      <= '0;
      major_len  <= '0;
      step_count <= '0;
      active     <= 1'b0;
    end else begin
      if (cfg_wr_en) absolute_mode <= cfg_wr_data;
      if (push) begin
        pos        <= pos_next;
        delta      <= delta_next;
        mag        <= mag_next;
        err        <= err_next;
        major      <= major_next;
        major_len  <= major_len_next;
        step_count <= step_count_next;
        active     <= active_next;
      end
    end
  end

  // two-entry result buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop)      count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) buf_q[wr_ptr] <= res_next;
  end

  assign res.step_mask = buf_q[rd_ptr].step_mask;
  assign res.dir_mask  = buf_q[rd_ptr].dir_mask;
  assign res.busy_res  = buf_q[rd_ptr].busy_res;
  assign res.rejected  = buf_q[rd_ptr].rejected;
  assign res.pos_x     = buf_q[rd_ptr].pos_x;
  assign res.pos_y     = buf_q[rd_ptr].pos_y;
  assign res.pos_u     = buf_q[rd_ptr].pos_u;
  assign res.pos_v     = buf_q[rd_ptr].pos_v;

endmodule

[tb/sv/fabs_checker.sv]
`timescale 1ns / 1ps
// Checker: mirrors the stepper's axis state from accepted commands and compares each result item.
module fabs_checker (
  input  logic clk,
  input  logic rst,
  input  logic cfg_wr_en,
  input  logic cfg_wr_data,
  fabs_cmd_if  cmd,
  fabs_res_if  res,
  output int   mismatch_count,
  output int   pending_results,
  output int   results_checked,
  output int   rejects_seen
);
  import fabs_pkg::*;

  logic    abs_mode;
  pos_t    axis_pos [AXES];
  delta_t  axis_delta [AXES];
  err_t    axis_err [AXES];
  int      major;
  longint  steps_given;
  logic    line_busy;
  result_t step_results_due [$];
  int      errs = 0;
  int      seen = 0;
  int      rej = 0;

  function automatic longint magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function result_t next_step_result(logic [1:0] m, coord_t tgt [AXES]);
    result_t r;
    longint  len, e, d;
    r = '0;
    case (m)
      MODE_START, MODE_SETPOS: begin
        if (line_busy) begin
          r.rejected = 1'b1;
        end else if (m == MODE_SETPOS) begin
          for (int i = 0; i < AXES; i++) axis_pos[i] = pos_t'(longint'(tgt[i]));
        end else begin
          for (int i = 0; i < AXES; i++) begin
            d = longint'(tgt[i]);
            if (abs_mode) d = d - longint'(axis_pos[i]);
            axis_delta[i] = delta_t'(d);
          end
          // later axis wins a tie
          major = 0;
          for (int i = 1; i < AXES; i++)
            if (magnitude(axis_delta[major]) <= magnitude(axis_delta[i])) major = i;
          for (int i = 0; i < AXES; i++)
            axis_err[i] = err_t'(magnitude(axis_delta[major]) / 2);
          steps_given = 0;
          line_busy = 1'b1;
        end
      end
      MODE_TICK: begin
        if (line_busy) begin
          len = magnitude(axis_delta[major]);
          if (steps_given < len) begin
            for (int i = 0; i < AXES; i++) begin
              if (i != major) begin
                e = longint'(axis_err[i]) - magnitude(axis_delta[i]);
                if (e < 0) begin
                  r.step_mask[i] = 1'b1;
                  e = e + len;
                end
                axis_err[i] = err_t'(e);
              end
            end
            r.step_mask[major] = 1'b1;
            steps_given++;
          end else begin
            for (int i = 0; i < AXES; i++) axis_pos[i] = axis_pos[i] + pos_t'(axis_delta[i]);
            line_busy = 1'b0;
          end
        end
      end
      default: ;
    endcase
    for (int i = 0; i < AXES; i++) r.dir_mask[i] = ~axis_delta[i][DELTA_BITS-1];
    r.busy_res = line_busy;
    r.pos_x = axis_pos[0];
    r.pos_y = axis_pos[1];
    r.pos_u = axis_pos[2];
    r.pos_v = axis_pos[3];
    return r;
  endfunction

  task automatic check_field(string name, logic signed [63:0] want, logic signed [63:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    coord_t  tgt [AXES];
    if (rst) begin
      abs_mode = 1'b0;
      for (int i = 0; i < AXES; i++) begin
        axis_pos[i] = '0;
        axis_delta[i] = '0;
        axis_err[i] = '0;
      end
      major = 0;
      steps_given = 0;
      line_busy = 1'b0;
      step_results_due.delete();
    end else begin
      if (cfg_wr_en) abs_mode = cfg_wr_data;
      if (res.valid && res.ready) begin
        if (step_results_due.size() == 0) begin
          $display("%0t: result item with none expected, expected nothing, got steps %0h pos %0d",
                   $time, res.step_mask, res.pos_x);
          errs++;
        end else begin
          want = step_results_due.pop_front();
          check_field("step_mask", want.step_mask, res.step_mask);
          check_field("dir_mask", want.dir_mask, res.dir_mask);
          check_field("busy_res", want.busy_res, res.busy_res);
          check_field("rejected", want.rejected, res.rejected);
          check_field("pos_x", want.pos_x, res.pos_x);
          check_field("pos_y", want.pos_y, res.pos_y);
          check_field("pos_u", want.pos_u, res.pos_u);
          check_field("pos_v", want.pos_v, res.pos_v);
          seen++;
          if (want.rejected) rej++;
        end
      end
      if (cmd.valid && cmd.ready) begin
        tgt = '{cmd.target_x, cmd.target_y, cmd.target_u, cmd.target_v};
        step_results_due.push_back(next_step_result(cmd.mode, tgt));
      end
    end
    mismatch_count  <= errs;
    pending_results <= step_results_due.size();
    results_checked <= seen;
    rejects_seen    <= rej;
  end

endmodule

[tb/sv/tb_four_axis_bresenham_stepper.sv]
`timescale 1ns / 1ps
// Testbench top: drives commands, result handshake and mode writes of the stepper, gives the verdict.
module tb_four_axis_bresenham_stepper;
  import fabs_pkg::*;

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam coord_t C_MAX = coord_t'((1 << (COORD_BITS - 1)) - 1);
  localparam coord_t C_MIN = coord_t'(-(1 << (COORD_BITS - 1)));
  localparam int PHASE_ITEMS = 500;
  localparam int HOLD_OFF = 150;

  logic clk, rst, cfg_wr_en, cfg_wr_data;
  int   mismatch_count, pending_results, results_checked, rejects_seen;
  int   items_sent = 0;
  int   lines_run = 0;
  int   results_taken = 0;
  logic abs_now = 1'b0;
  bit   send_burst = 1'b0;
  bit   take_burst = 1'b0;
  longint known_pos [AXES] = '{default: 0};

  fabs_cmd_if cmd_ch ();
  fabs_res_if res_ch ();

  four_axis_bresenham_stepper dut (
    .clk, .rst, .cfg_wr_en, .cfg_wr_data, .cmd(cmd_ch), .res(res_ch)
  );

  fabs_checker u_check (
    .clk, .rst, .cfg_wr_en, .cfg_wr_data, .cmd(cmd_ch), .res(res_ch),
    .mismatch_count, .pending_results, .results_checked, .rejects_seen
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int draw_wait(inout bit burst);
    if ($urandom_range(0, 39) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, 18);
  endfunction

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic coord_t any_coord();
    return coord_t'($urandom);
  endfunction

  function automatic bit fits_coord(longint v);
    return v >= longint'(C_MIN) && v <= longint'(C_MAX);
  endfunction

  task automatic send_cmd(input logic [1:0] m, input coord_t x, y, u, v);
    int gap;
    gap = draw_wait(send_burst);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.mode <= m;
    cmd_ch.target_x <= x;
    cmd_ch.target_y <= y;
    cmd_ch.target_u <= u;
    cmd_ch.target_v <= v;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic write_mode(input logic v);
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    abs_now = v;
  endtask

  task automatic set_positions(input coord_t x, y, u, v);
    send_cmd(MODE_SETPOS, x, y, u, v);
    known_pos = '{longint'(x), longint'(y), longint'(u), longint'(v)};
  endtask

  task automatic noise_item();
    if ($urandom_range(0, 1) == 0) send_cmd(MODE_TICK, any_coord(), any_coord(), any_coord(),
                                            any_coord());
    else send_cmd(MODE_SPARE, any_coord(), any_coord(), any_coord(), any_coord());
  endtask

  // commands while a line runs: all must be dropped
  task automatic busy_intrusion();
    case ($urandom_range(0, 2))
      0: send_cmd(MODE_START, any_coord(), any_coord(), any_coord(), any_coord());
      1: send_cmd(MODE_SETPOS, any_coord(), any_coord(), any_coord(), any_coord());
      default: send_cmd(MODE_SPARE, any_coord(), any_coord(), any_coord(), any_coord());
    endcase
  endtask

  task automatic run_line(input coord_t x, y, u, v);
    coord_t t [AXES];
    longint d [AXES];
    longint len;
    t = '{x, y, u, v};
    len = 0;
    for (int i = 0; i < AXES; i++) begin
      d[i] = abs_now ? longint'(t[i]) - known_pos[i] : longint'(t[i]);
      if (mag(d[i]) > len) len = mag(d[i]);
    end
    send_cmd(MODE_START, x, y, u, v);
    for (longint k = 0; k <= len; k++) begin
      if ($urandom_range(0, 7) == 0) busy_intrusion();
      send_cmd(MODE_TICK, any_coord(), any_coord(), any_coord(), any_coord());
    end
    for (int i = 0; i < AXES; i++) known_pos[i] += d[i];
    lines_run++;
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) noise_item();
  endtask

  task automatic random_line();
    longint d [AXES];
    longint t [AXES];
    longint span, m;
    bit     ok;
    span = ($urandom_range(0, 24) == 0) ? 300 : 12;
    case ($urandom_range(0, 9))
      0: d = '{default: 0};
      1: begin
        m = $urandom_range(0, span);
        for (int i = 0; i < AXES; i++) d[i] = $urandom_range(0, 1) ? m : -m;
      end
      default: begin
        for (int i = 0; i < AXES; i++) d[i] = longint'($urandom_range(0, 2 * span)) - span;
      end
    endcase
    if ($urandom_range(0, 2) == 0)
      set_positions(any_coord(), any_coord(), any_coord(), any_coord());
    if (abs_now) begin
      ok = 1'b1;
      for (int i = 0; i < AXES; i++) begin
        t[i] = known_pos[i] + d[i];
        if (!fits_coord(t[i])) ok = 1'b0;
      end
      if (!ok) begin
        set_positions('0, '0, '0, '0);
        t = d;
      end
    end else begin
      t = d;
    end
    run_line(coord_t'(t[0]), coord_t'(t[1]), coord_t'(t[2]), coord_t'(t[3]));
  endtask

  task automatic random_phase(input logic v);
    int stop;
    write_mode(v);
    stop = items_sent + PHASE_ITEMS;
    while (items_sent < stop) begin
      case ($urandom_range(0, 9))
        0, 1: noise_item();
        2: set_positions(any_coord(), any_coord(), any_coord(), any_coord());
        default: random_line();
      endcase
    end
  endtask

  initial begin
    int stall;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (results_taken == 600 || results_taken == 1900) stall = HOLD_OFF;
      else stall = draw_wait(take_burst);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
      while (!res_ch.valid) @(posedge clk);
      results_taken++;
    end
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    cmd_ch.valid <= 1'b0;
    cmd_ch.mode <= MODE_TICK;
    cmd_ch.target_x <= '0;
    cmd_ch.target_y <= '0;
    cmd_ch.target_u <= '0;
    cmd_ch.target_v <= '0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= 1'b0;
    rst <= 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    write_mode(1'b0);
    send_cmd(MODE_TICK, '0, '0, '0, '0);
    send_cmd(MODE_SPARE, C_MAX, C_MIN, C_MAX, C_MIN);
    // zero-length line, with drops while busy
    send_cmd(MODE_START, '0, '0, '0, '0);
    send_cmd(MODE_START, C_MAX, C_MIN, C_MAX, C_MIN);
    send_cmd(MODE_SETPOS, C_MIN, C_MAX, C_MIN, C_MAX);
    send_cmd(MODE_SPARE, C_MAX, C_MAX, C_MAX, C_MAX);
    send_cmd(MODE_TICK, '0, '0, '0, '0);
    lines_run++;
    set_positions(C_MIN, C_MAX, '0, coord_t'(-1));
    run_line(coord_t'(3), coord_t'(-3), coord_t'(2), coord_t'(-1));
    run_line(coord_t'(-2), coord_t'(2), coord_t'(-2), coord_t'(2));

    write_mode(1'b1);
    set_positions(C_MAX, C_MIN, coord_t'(100), coord_t'(-100));
    run_line(C_MAX, C_MIN, coord_t'(100), coord_t'(-100));
    run_line(coord_t'(C_MAX - 1), coord_t'(C_MIN + 1), coord_t'(100), coord_t'(-99));

    random_phase(1'b0);
    random_phase(1'b1);
    random_phase(1'b0);
    random_phase(1'b1);

    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("coverage: %0d command items, %0d lines in relative and absolute mode",
             items_sent, lines_run);
    $display("coverage: %0d result items compared, %0d busy drops, two long receiver stalls",
             results_checked, rejects_seen);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[filelist.f]
src/fabs_pkg.sv
src/fabs_if.sv
src/four_axis_bresenham_stepper.sv
tb/sv/fabs_checker.sv
tb/sv/tb_four_axis_bresenham_stepper.sv
